>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/frm_pkg.sv
// Package: types and constants of the frame rate monitor
`timescale 1ns / 1ps
package frm_pkg;
    localparam int MAX_FRAMES_DEF = 64;
    localparam int FIU_W          = 7;
    localparam int WIN_W          = 40;
    localparam int TS_W           = 32;
    localparam int FPS_W          = 24;
    localparam int SCALE_W        = 28;
    localparam int SUM_W          = 41;
    localparam logic [SCALE_W-1:0] FPS_SCALE = 28'd256000000;
    localparam logic [FPS_W-1:0]   FPS_SAT   = 24'hFFFFFF;
    localparam logic [FIU_W-1:0]   FIU_RESET = 7'd64;
    localparam logic [WIN_W-1:0]   WIN_RESET = 40'hFF_FFFF_FFFF;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic REG_FIU = 1'b0;
    localparam logic REG_WIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WALK, ST_DIV_LOAD, ST_DIV_RUN, ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        DIV_AVG, DIV_MAX, DIV_MIN
    } t_div_sel;
endpackage

>>> rtl/frame_rate_monitor.sv
// Top level: frame-time ring with fps statistics
//
//  channel  dir  handshake                fields
//  in       in   i_in_valid / o_in_stall   command, timestamp_us
//  out      out  o_out_valid / i_out_stall status, last_frame_us, avg/min/max fps
//  cfg      in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Begin, end and reset are answered in the cycle after they are taken. A query of a
// non-empty ring walks the ring through the memory read port, then runs the shared
// radix-2 divider three times, for the average, max and min fps.
// Synchronous active-low reset; the ring itself is not cleared.
// A new beat is taken while the last result waits, unless the result is stalled or the monitor is busy.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frame_rate_monitor #(
    parameter int MAX_FRAMES = frm_pkg::MAX_FRAMES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_command,
    input  logic [frm_pkg::TS_W-1:0]   i_timestamp_us,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_status,
    output logic [frm_pkg::TS_W-1:0]   o_last_frame_us,
    output logic [frm_pkg::FPS_W-1:0]  o_avg_fps,
    output logic [frm_pkg::FPS_W-1:0]  o_min_fps,
    output logic [frm_pkg::FPS_W-1:0]  o_max_fps,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [frm_pkg::WIN_W-1:0]  i_cfg_data
);
    localparam int AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int NUM_W = CNT_W + frm_pkg::SCALE_W;
    localparam int RW    = frm_pkg::SUM_W + 1;
    localparam int SW    = $clog2(NUM_W + 1);
    localparam int TW    = frm_pkg::TS_W;
    localparam int FW    = frm_pkg::FPS_W;

    logic [TW-1:0] r_ring [MAX_FRAMES];
    logic [TW-1:0] r_rd_data;
    logic          ring_we;
    logic [AW-1:0] ring_waddr, ring_raddr;
    logic [TW-1:0] ring_wdata;

    frm_pkg::t_state   r_state, n_state;
    frm_pkg::t_div_sel r_sel, n_sel;
    logic [frm_pkg::FIU_W-1:0] r_fiu, n_fiu;
    logic [frm_pkg::WIN_W-1:0] r_win, n_win;
    logic [TW-1:0]    r_last_time, n_last_time, r_gap, n_gap, r_last_dur, n_last_dur;
    logic [AW-1:0]    r_wpos, n_wpos;
    logic             r_full, n_full, r_run, n_run;
    logic [CNT_W-1:0] r_count, n_count, r_issue, n_issue, r_rd_pos, n_rd_pos;
    logic [CNT_W-1:0] r_avg_cnt, n_avg_cnt;
    logic             r_rd_vld, n_rd_vld;
    logic [frm_pkg::SUM_W-1:0] r_sum, n_sum, r_div, n_div;
    logic [TW-1:0]    r_long, n_long, r_short, n_short;
    logic [NUM_W-1:0] r_num, n_num;
    logic [RW-1:0]    r_rem, n_rem;
    logic [SW-1:0]    r_step, n_step;
    logic [FW-1:0]    r_avg, n_avg, r_min, n_min, r_max, n_max;
    logic             r_out_valid, n_out_valid, r_status, n_status;
    logic [TW-1:0]    r_out_last, n_out_last;
    logic [FW-1:0]    r_out_avg, n_out_avg, r_out_min, n_out_min, r_out_max, n_out_max;

    logic             accept;
    logic [CNT_W-1:0] len;
    logic [TW-1:0]    elapsed;
    logic [TW:0]      dur_sum;
    logic [CNT_W-1:0] wpos_inc;
    logic [RW-1:0]    rem_sh;
    logic             q_bit;
    logic [NUM_W-1:0] q_fin;
    logic [FW-1:0]    fps_res;
    logic [frm_pkg::SUM_W-1:0] sum_add;

    always_comb begin
        if (r_fiu == '0) begin
            len = CNT_W'(1);
        end else if (int'(r_fiu) > MAX_FRAMES) begin
            len = CNT_W'(MAX_FRAMES);
        end else begin
            len = CNT_W'(r_fiu);
        end
    end

    assign o_in_stall = (r_state != frm_pkg::ST_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign elapsed    = (i_timestamp_us > r_last_time) ? i_timestamp_us - r_last_time : '0;
    assign dur_sum    = {1'b0, r_gap} + {1'b0, elapsed};
    assign wpos_inc   = CNT_W'(r_wpos) + CNT_W'(1);
    assign rem_sh     = {r_rem[RW-2:0], r_num[NUM_W-1]};
    assign q_bit      = rem_sh >= {1'b0, r_div};
    assign q_fin      = {r_num[NUM_W-2:0], q_bit};
    assign sum_add    = r_sum + frm_pkg::SUM_W'(r_rd_data);

    always_comb begin
        if (r_div == '0) begin
            fps_res = '0;
        end else if (|q_fin[NUM_W-1:FW]) begin
            fps_res = frm_pkg::FPS_SAT;
        end else begin
            fps_res = q_fin[FW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;      n_sel = r_sel;
        n_fiu = r_fiu;          n_win = r_win;
        n_last_time = r_last_time; n_gap = r_gap; n_last_dur = r_last_dur;
        n_wpos = r_wpos;        n_full = r_full;  n_run = r_run;
        n_count = r_count;      n_issue = r_issue; n_rd_pos = r_rd_pos;
        n_avg_cnt = r_avg_cnt;  n_rd_vld = 1'b0;
        n_sum = r_sum;          n_div = r_div;
        n_long = r_long;        n_short = r_short;
        n_num = r_num;          n_rem = r_rem;    n_step = r_step;
        n_avg = r_avg;          n_min = r_min;    n_max = r_max;
        n_out_valid = r_out_valid && i_out_stall;
        n_status = r_status;    n_out_last = r_out_last;
        n_out_avg = r_out_avg;  n_out_min = r_out_min; n_out_max = r_out_max;
        ring_we = 1'b0;  ring_waddr = r_wpos;  ring_wdata = '0;
        ring_raddr = r_issue[AW-1:0];

        if (i_cfg_we) begin
            if (i_cfg_idx == frm_pkg::REG_FIU) begin
                n_fiu  = i_cfg_data[frm_pkg::FIU_W-1:0];
                n_wpos = '0;
                n_full = 1'b0;
                n_run  = 1'b0;
            end else begin
                n_win = i_cfg_data;
            end
        end

        unique case (r_state)
            frm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_status = 1'b0;
                    n_out_avg = '0; n_out_min = '0; n_out_max = '0;
                    n_out_valid = 1'b1;
                    unique case (i_command)
                        frm_pkg::CMD_BEGIN: begin
                            if (r_run) begin
                                n_status = 1'b1;
                            end else begin
                                n_gap = elapsed;
                                n_last_time = i_timestamp_us;
                                n_run = 1'b1;
                            end
                        end
                        frm_pkg::CMD_END: begin
                            if (!r_run) begin
                                n_status = 1'b1;
                            end else begin
                                ring_we = 1'b1;
                                ring_wdata = dur_sum[TW] ? '1 : dur_sum[TW-1:0];
                                n_last_dur = ring_wdata;
                                if (wpos_inc >= len) begin
                                    n_wpos = '0;
                                    n_full = 1'b1;
                                end else begin
                                    n_wpos = wpos_inc[AW-1:0];
                                end
                                n_last_time = i_timestamp_us;
                                n_run = 1'b0;
                            end
                        end
                        frm_pkg::CMD_RESET: begin
                            n_last_time = i_timestamp_us;
                            n_wpos = '0;
                            n_full = 1'b0;
                            n_run  = 1'b0;
                        end
                        frm_pkg::CMD_QUERY: begin
                            n_count = r_full ? len : CNT_W'(r_wpos);
                            if (n_count != '0) begin
                                n_out_valid = r_out_valid && i_out_stall;
                                n_avg_cnt = n_count;
                                n_issue = '0;
                                n_sum = '0; n_long = '0; n_short = '0;
                                n_state = frm_pkg::ST_WALK;
                            end
                        end
                        default: ;
                    endcase
                    n_out_last = (n_wpos != '0 || n_full) ? n_last_dur : '0;
                end
            end
            frm_pkg::ST_WALK: begin
                if (r_issue < r_count) begin
                    n_issue  = r_issue + CNT_W'(1);
                    n_rd_pos = r_issue + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld) begin
                    n_sel   = frm_pkg::DIV_AVG;
                    n_state = frm_pkg::ST_DIV_LOAD;
                end
                if (r_rd_vld) begin
                    if (r_sum < {1'b0, r_win}) begin
                        n_sum = sum_add;
                        if (sum_add >= {1'b0, r_win}) n_avg_cnt = r_rd_pos;
                    end
                    if (r_rd_data > r_long) n_long = r_rd_data;
                    if (r_rd_pos == CNT_W'(1) || r_rd_data < r_short) n_short = r_rd_data;
                end
            end
            frm_pkg::ST_DIV_LOAD: begin
                n_rem  = '0;
                n_step = '0;
                unique case (r_sel)
                    frm_pkg::DIV_AVG: begin
                        n_num = NUM_W'(r_avg_cnt) * NUM_W'(frm_pkg::FPS_SCALE);
                        n_div = r_sum;
                    end
                    frm_pkg::DIV_MAX: begin
                        n_num = NUM_W'(frm_pkg::FPS_SCALE);
                        n_div = frm_pkg::SUM_W'(r_short);
                    end
                    default: begin
                        n_num = NUM_W'(frm_pkg::FPS_SCALE);
                        n_div = frm_pkg::SUM_W'(r_long);
                    end
                endcase
                n_state = frm_pkg::ST_DIV_RUN;
            end
            frm_pkg::ST_DIV_RUN: begin
                n_rem  = q_bit ? rem_sh - {1'b0, r_div} : rem_sh;
                n_num  = q_fin;
                n_step = r_step + SW'(1);
                if (r_step == SW'(NUM_W - 1)) begin
                    unique case (r_sel)
                        frm_pkg::DIV_AVG: begin
                            n_avg = fps_res;
                            n_sel = frm_pkg::DIV_MAX;
                            n_state = frm_pkg::ST_DIV_LOAD;
                        end
                        frm_pkg::DIV_MAX: begin
                            n_max = fps_res;
                            n_sel = frm_pkg::DIV_MIN;
                            n_state = frm_pkg::ST_DIV_LOAD;
                        end
                        default: begin
                            n_min = fps_res;
                            n_state = frm_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            frm_pkg::ST_FINISH: begin
                n_out_valid = 1'b1;
                n_out_avg = r_avg;
                n_out_min = r_min;
                n_out_max = r_max;
                n_state = frm_pkg::ST_IDLE;
            end
            default: n_state = frm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_waddr] <= ring_wdata;
        end
        r_rd_data <= r_ring[ring_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frm_pkg::ST_IDLE;
            r_sel <= frm_pkg::DIV_AVG;
            r_fiu <= frm_pkg::FIU_RESET;
            r_win <= frm_pkg::WIN_RESET;
            r_last_time <= '0;
            r_gap <= '0;
            r_last_dur <= '0;
            r_wpos <= '0;
            r_full <= 1'b0;
            r_run <= 1'b0;
            r_rd_vld <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel <= n_sel;
            r_fiu <= n_fiu;
            r_win <= n_win;
            r_last_time <= n_last_time;
            r_gap <= n_gap;
            r_last_dur <= n_last_dur;
            r_wpos <= n_wpos;
            r_full <= n_full;
            r_run <= n_run;
            r_rd_vld <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;   r_issue <= n_issue;  r_rd_pos <= n_rd_pos;
        r_avg_cnt <= n_avg_cnt;
        r_sum <= n_sum;       r_div <= n_div;
        r_long <= n_long;     r_short <= n_short;
        r_num <= n_num;       r_rem <= n_rem;      r_step <= n_step;
        r_avg <= n_avg;       r_min <= n_min;      r_max <= n_max;
        r_status <= n_status; r_out_last <= n_out_last;
        r_out_avg <= n_out_avg; r_out_min <= n_out_min; r_out_max <= n_out_max;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_last_frame_us = r_out_last;
    assign o_avg_fps       = r_out_avg;
    assign o_min_fps       = r_out_min;
    assign o_max_fps       = r_out_max;

    `ASSERT_ALWAYS(a_wpos_in_ring, i_clk, i_rst_n, CNT_W'(r_wpos) < len)
    `ASSERT_IMPLIES(a_busy_no_out, i_clk, i_rst_n, r_state != frm_pkg::ST_IDLE, !r_out_valid)
    `ASSERT_IMPLIES(a_rd_in_walk, i_clk, i_rst_n, r_rd_vld, r_state == frm_pkg::ST_WALK)
endmodule
